@@ design/pts_pkg.sv @@
// Package for the priority task scheduler: sizes, action and status codes,
// request and result types, and the ready-set priority encoder.
// No dependencies.
package pts_pkg;

    localparam int NUM_TASK_PRIOS = 16;
    localparam int MAX_USER_TASKS = 8;
    localparam int PRIO_W         = $clog2(NUM_TASK_PRIOS);
    localparam int TICKS_W        = 16;
    localparam int MADE_W         = $clog2(MAX_USER_TASKS + 2);
    localparam int ISR_W          = 8;
    localparam int CNT_W          = 32;
    localparam logic [PRIO_W-1:0] IDLE_TASK = PRIO_W'(NUM_TASK_PRIOS - 1);
    localparam logic [ISR_W-1:0]  ISR_MAX   = '1;

    typedef enum logic [2:0] {
        ACT_START  = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_DELAY  = 3'd2,
        ACT_BLOCK  = 3'd3,
        ACT_WAKE   = 3'd4,
        ACT_TICK   = 3'd5,
        ACT_ISR_IN = 3'd6,
        ACT_ISR_OUT = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_IN_USE  = 3'd1,
        ST_FULL    = 3'd2,
        ST_NO_USER = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [PRIO_W-1:0]   task_priority;
        logic [TICKS_W-1:0]  delay_ticks;
    } t_req;

    typedef struct packed {
        logic [PRIO_W-1:0]         current_task;
        logic                      switched;
        t_status                   status;
        logic [NUM_TASK_PRIOS-1:0] ready_set;
    } t_result;

    typedef struct packed {
        logic               tick;
        logic               load;
        logic [PRIO_W-1:0]  load_idx;
        logic [TICKS_W-1:0] load_val;
    } t_cnt_cmd;

    function automatic logic [PRIO_W-1:0] first_ready(input logic [NUM_TASK_PRIOS-1:0] mask);
        logic [PRIO_W-1:0] sel;
        sel = IDLE_TASK;
        for (int p = NUM_TASK_PRIOS - 1; p >= 0; p--) begin
            if (mask[p]) begin
                sel = PRIO_W'(p);
            end
        end
        return sel;
    endfunction

endpackage

@@ design/pts_countdown.sv @@
// Per-task delay countdown lanes of the priority task scheduler.
// Depends on pts_pkg for sizes and the command struct.
module pts_countdown (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pts_pkg::t_cnt_cmd                  i_cmd,
    input  logic [pts_pkg::NUM_TASK_PRIOS-1:0] i_delayed,
    output logic [pts_pkg::NUM_TASK_PRIOS-1:0] o_expire
);

    logic [pts_pkg::TICKS_W-1:0] r_left [pts_pkg::NUM_TASK_PRIOS];

    for (genvar p = 0; p < pts_pkg::NUM_TASK_PRIOS; p++) begin : g_lane
        logic active;
        assign active      = i_cmd.tick && i_delayed[p] && (r_left[p] != '0);
        assign o_expire[p] = i_delayed[p] && (r_left[p] == pts_pkg::TICKS_W'(1));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_left[p] <= '0;
            end else if (i_cmd.load && (i_cmd.load_idx == pts_pkg::PRIO_W'(p))) begin
                r_left[p] <= i_cmd.load_val;
            end else if (active) begin
                r_left[p] <= r_left[p] - pts_pkg::TICKS_W'(1);
            end
        end
    end

endmodule

@@ design/priority_task_scheduler_unit.sv @@
// Top level of the priority task scheduler.
// Depends on pts_pkg and pts_countdown.
//
// Usage: a request (action, task priority, delay ticks) is taken at a rising
// edge where start is high and busy is low. busy stays low, so a request may
// be given in every cycle. The request is registered, then the whole action
// is worked out combinationally from the task masks, the countdown lanes and
// the ready-set priority encoder, and the result is registered. The result
// is on o_result with o_valid high for one cycle, after the request has
// passed the request register and the result register. Throughput: one
// request per cycle. Results come out in request order, one per request.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset (synchronous, active low) drops any request in flight, leaves only
// the idle task present and ready, clears all delays, the ISR depth and the
// switch and tick counters, and marks the kernel as not started with no task running.
module priority_task_scheduler_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pts_pkg::t_req    i_req,
    output logic             o_valid,
    output pts_pkg::t_result o_result
);

    localparam int N = pts_pkg::NUM_TASK_PRIOS;

    logic                         r_req_valid;
    pts_pkg::t_req                r_req;
    logic [N-1:0]                 r_present, n_present;
    logic [N-1:0]                 r_ready, n_ready;
    logic [N-1:0]                 r_delayed, n_delayed;
    logic [pts_pkg::PRIO_W-1:0]   r_running, n_running;
    logic                         r_running_valid, n_running_valid;
    logic                         r_started, n_started;
    logic [pts_pkg::ISR_W-1:0]    r_isr_depth, n_isr_depth;
    logic [pts_pkg::MADE_W-1:0]   r_tasks_made, n_tasks_made;
    logic [pts_pkg::CNT_W-1:0]    r_switch_count, n_switch_count;
    logic [pts_pkg::CNT_W-1:0]    r_tick_count, n_tick_count;
    logic                         r_valid;
    pts_pkg::t_result             r_result, n_result;

    pts_pkg::t_cnt_cmd            cnt_cmd;
    logic [N-1:0]                 expire;
    logic [N-1:0]                 prio_bit;
    logic [N-1:0]                 run_bit;
    logic                         do_sched;
    logic                         sw;
    logic [pts_pkg::PRIO_W-1:0]   pick;
    pts_pkg::t_status             status;

    assign busy = 1'b0;

    pts_countdown u_countdown (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cnt_cmd),
        .i_delayed (r_delayed),
        .o_expire  (expire)
    );

    assign prio_bit = N'(1) << r_req.task_priority;
    assign run_bit  = N'(1) << r_running;

    always_comb begin
        n_present       = r_present;
        n_ready         = r_ready;
        n_delayed       = r_delayed;
        n_running       = r_running;
        n_running_valid = r_running_valid;
        n_started       = r_started;
        n_isr_depth     = r_isr_depth;
        n_tasks_made    = r_tasks_made;
        n_switch_count  = r_switch_count;
        n_tick_count    = r_tick_count;
        cnt_cmd         = '0;
        do_sched        = 1'b0;
        sw              = 1'b0;
        status          = pts_pkg::ST_OK;

        if (r_req_valid) begin
            case (r_req.action)
                pts_pkg::ACT_START: begin
                    if (r_started) begin
                        status = pts_pkg::ST_INVALID;
                    end else if (r_tasks_made <= pts_pkg::MADE_W'(1)) begin
                        status = pts_pkg::ST_NO_USER;
                    end else begin
                        n_started = 1'b1;
                        do_sched  = 1'b1;
                    end
                end
                pts_pkg::ACT_CREATE: begin
                    if ((r_present & prio_bit) != '0) begin
                        status = pts_pkg::ST_IN_USE;
                    end else if (r_tasks_made > pts_pkg::MADE_W'(pts_pkg::MAX_USER_TASKS)) begin
                        status = pts_pkg::ST_FULL;
                    end else begin
                        n_tasks_made     = r_tasks_made + pts_pkg::MADE_W'(1);
                        n_present        = r_present | prio_bit;
                        n_ready          = r_ready | prio_bit;
                        n_delayed        = r_delayed & ~prio_bit;
                        cnt_cmd.load     = 1'b1;
                        cnt_cmd.load_idx = r_req.task_priority;
                        do_sched         = r_started && (r_isr_depth == '0);
                    end
                end
                pts_pkg::ACT_DELAY, pts_pkg::ACT_BLOCK: begin
                    if ((r_req.action == pts_pkg::ACT_DELAY) && (r_req.delay_ticks == '0)) begin
                        status = pts_pkg::ST_OK;
                    end else if (!r_started || !r_running_valid || (r_isr_depth != '0)
                                 || (r_running >= pts_pkg::IDLE_TASK)) begin
                        status = pts_pkg::ST_INVALID;
                    end else begin
                        n_ready = r_ready & ~run_bit;
                        if (r_req.action == pts_pkg::ACT_DELAY) begin
                            n_delayed        = r_delayed | run_bit;
                            cnt_cmd.load     = 1'b1;
                            cnt_cmd.load_idx = r_running;
                            cnt_cmd.load_val = r_req.delay_ticks;
                        end
                        do_sched = 1'b1;
                    end
                end
                pts_pkg::ACT_WAKE: begin
                    if ((r_present & prio_bit) == '0) begin
                        status = pts_pkg::ST_INVALID;
                    end else if ((r_ready & prio_bit) == '0) begin
                        n_ready          = r_ready | prio_bit;
                        n_delayed        = r_delayed & ~prio_bit;
                        cnt_cmd.load     = 1'b1;
                        cnt_cmd.load_idx = r_req.task_priority;
                        do_sched         = r_started && (r_isr_depth == '0);
                    end
                end
                pts_pkg::ACT_TICK: begin
                    n_tick_count = r_tick_count + pts_pkg::CNT_W'(1);
                    cnt_cmd.tick = 1'b1;
                    n_ready      = r_ready | expire;
                    n_delayed    = r_delayed & ~expire;
                end
                pts_pkg::ACT_ISR_IN: begin
                    if (r_isr_depth == pts_pkg::ISR_MAX) begin
                        status = pts_pkg::ST_INVALID;
                    end else begin
                        n_isr_depth = r_isr_depth + pts_pkg::ISR_W'(1);
                    end
                end
                pts_pkg::ACT_ISR_OUT: begin
                    if (r_isr_depth == '0) begin
                        status = pts_pkg::ST_INVALID;
                    end else begin
                        n_isr_depth = r_isr_depth - pts_pkg::ISR_W'(1);
                        do_sched    = r_started && (r_isr_depth == pts_pkg::ISR_W'(1));
                    end
                end
                default: begin
                    status = pts_pkg::ST_INVALID;
                end
            endcase
        end

        pick = pts_pkg::first_ready(n_ready);
        if (do_sched && (!r_running_valid || (pick != r_running))) begin
            n_running       = pick;
            n_running_valid = 1'b1;
            n_switch_count  = r_switch_count + pts_pkg::CNT_W'(1);
            sw              = 1'b1;
        end

        n_result.current_task = n_running;
        n_result.switched     = sw;
        n_result.status       = status;
        n_result.ready_set    = n_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid     <= 1'b0;
            r_present       <= N'(1) << pts_pkg::IDLE_TASK;
            r_ready         <= N'(1) << pts_pkg::IDLE_TASK;
            r_delayed       <= '0;
            r_running       <= '0;
            r_running_valid <= 1'b0;
            r_started       <= 1'b0;
            r_isr_depth     <= '0;
            r_tasks_made    <= pts_pkg::MADE_W'(1);
            r_switch_count  <= '0;
            r_tick_count    <= '0;
            r_valid         <= 1'b0;
        end else begin
            r_req_valid     <= start && !busy;
            r_present       <= n_present;
            r_ready         <= n_ready;
            r_delayed       <= n_delayed;
            r_running       <= n_running;
            r_running_valid <= n_running_valid;
            r_started       <= n_started;
            r_isr_depth     <= n_isr_depth;
            r_tasks_made    <= n_tasks_made;
            r_switch_count  <= n_switch_count;
            r_tick_count    <= n_tick_count;
            r_valid         <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        if (r_req_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ design/pts_checker.sv @@
// Port-level checks for the priority task scheduler, bound to the top level.
// Depends on pts_pkg and priority_task_scheduler_unit.
module pts_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input pts_pkg::t_req    i_req,
    input logic             o_valid,
    input pts_pkg::t_result o_result
);

    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("request did not produce a result two cycles later");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result strobe without a matching request");

    a_error_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != pts_pkg::ST_OK)) |-> !o_result.switched)
        else $error("context switch reported on a failed request");

    a_switch_to_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.switched) |-> o_result.ready_set[o_result.current_task])
        else $error("switched to a task that is not ready");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.ready_set[pts_pkg::IDLE_TASK])
        else $error("idle task left the ready set");

endmodule

bind priority_task_scheduler_unit pts_checker u_pts_checker (.*);
